// ===== hdl/bqf_pkg.sv =====
package bqf_pkg;

    // Fixed field widths of the ports and the accumulator
    localparam int COEFF_W   = 32;
    localparam int PORT_W    = 32;
    localparam int ACC_W     = 64;
    localparam int NUM_REGS  = 5;
    localparam int REG_IDX_W = 3;

    // Configuration register indexes
    typedef enum logic [REG_IDX_W-1:0] {
        REG_FF_COEFF_0 = 3'd0,
        REG_FF_COEFF_1 = 3'd1,
        REG_FF_COEFF_2 = 3'd2,
        REG_FB_COEFF_1 = 3'd3,
        REG_FB_COEFF_2 = 3'd4
    } reg_index_t;

    // Full coefficient set handed to the datapath
    typedef struct packed {
        logic signed [COEFF_W-1:0] ff_coeff_0;
        logic signed [COEFF_W-1:0] ff_coeff_1;
        logic signed [COEFF_W-1:0] ff_coeff_2;
        logic signed [COEFF_W-1:0] fb_coeff_1;
        logic signed [COEFF_W-1:0] fb_coeff_2;
    } coeff_set_t;

endpackage

// ===== hdl/biquad_filter_q16.sv =====
// Direct-form-I biquad on signed fixed-point samples (Q16.16 by default).
// Input channel: sample_valid / sample_stall carry one request of
// sample_in; only its low SAMPLE_WIDTH bits are used. Output channel:
// result_valid / result_stall carry sample_out and overflow, one result
// per input sample, in order.
// A sample accepted lands in the input register; as it advances, its
// result is registered in the result register and shown on the outputs.
// Throughput is one sample per cycle while the receiver does not stall;
// the limit is the combinational loop from the output history through
// the feedback multiplies, sum and rounding. Coefficients are written
// through cfg_we / cfg_index / cfg_data; the user must do so only while
// the filter is idle, which the block itself does not enforce. Unknown
// indexes are ignored. Reset clears the sample histories, empties both
// pipeline registers and loads the coefficients for a unity pass-through
// filter. When the receiver stalls, the result holds; the input register
// holds its sample and sample_stall rises until the result is taken.
module biquad_filter_q16
    import bqf_pkg::*;
#(
    parameter int FRAC_BITS    = 16,
    parameter int SAMPLE_WIDTH = 32
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [REG_IDX_W-1:0]     cfg_index,
    input  logic [COEFF_W-1:0]       cfg_data,
    input  logic                     sample_valid,
    output logic                     sample_stall,
    input  logic signed [PORT_W-1:0] sample_in,
    output logic                     result_valid,
    input  logic                     result_stall,
    output logic signed [PORT_W-1:0] sample_out,
    output logic                     overflow
);

    coeff_set_t                     coeffs;
    logic                           in_valid_reg;
    logic signed [SAMPLE_WIDTH-1:0] in_sample_reg;
    logic                           out_valid_reg;
    logic signed [PORT_W-1:0]       out_sample_reg;
    logic                           out_ovf_reg;
    logic                           advance;
    logic                           accept;
    logic signed [PORT_W-1:0]       y_calc;
    logic                           ovf_calc;

    bqf_coeff_regs #(
        .FRAC_BITS (FRAC_BITS)
    ) u_coeff_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .coeffs    (coeffs)
    );

    bqf_datapath #(
        .FRAC_BITS    (FRAC_BITS),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .x_in    (in_sample_reg),
        .coeffs  (coeffs),
        .y_out   (y_calc),
        .ovf_out (ovf_calc)
    );

    // Advance when the result register is empty or being drained
    assign advance      = in_valid_reg && (!out_valid_reg || !result_stall);
    assign sample_stall = in_valid_reg && !advance;
    assign accept       = sample_valid && !sample_stall;

    // Hold the request in the input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_sample_reg <= sample_in[SAMPLE_WIDTH-1:0];
        end
    end

    // Capture the result, drop it once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_sample_reg <= y_calc;
            out_ovf_reg    <= ovf_calc;
        end
    end

    assign result_valid = out_valid_reg;
    assign sample_out   = out_sample_reg;
    assign overflow     = out_ovf_reg;

endmodule

// ===== hdl/bqf_coeff_regs.sv =====
module bqf_coeff_regs
    import bqf_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [REG_IDX_W-1:0] cfg_index,
    input  logic [COEFF_W-1:0]   cfg_data,
    output coeff_set_t           coeffs
);

    // Unity gain on the current input at reset
    localparam logic [COEFF_W-1:0] UNITY = COEFF_W'(1) << FRAC_BITS;

    // Reset set: unity on the current input, every other coefficient zero
    localparam coeff_set_t COEFF_RESET = {UNITY, {(4*COEFF_W){1'b0}}};

    coeff_set_t coeffs_reg;

    // Write one coefficient, ignore unknown indexes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coeffs_reg <= COEFF_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FF_COEFF_0: coeffs_reg.ff_coeff_0 <= cfg_data;
                REG_FF_COEFF_1: coeffs_reg.ff_coeff_1 <= cfg_data;
                REG_FF_COEFF_2: coeffs_reg.ff_coeff_2 <= cfg_data;
                REG_FB_COEFF_1: coeffs_reg.fb_coeff_1 <= cfg_data;
                REG_FB_COEFF_2: coeffs_reg.fb_coeff_2 <= cfg_data;
                default:        ;
            endcase
        end
    end

    assign coeffs = coeffs_reg;

endmodule

// ===== hdl/bqf_datapath.sv =====
module bqf_datapath
    import bqf_pkg::*;
#(
    parameter int FRAC_BITS    = 16,
    parameter int SAMPLE_WIDTH = 32
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           advance,
    input  logic signed [SAMPLE_WIDTH-1:0] x_in,
    input  coeff_set_t                     coeffs,
    output logic signed [PORT_W-1:0]       y_out,
    output logic                           ovf_out
);

    localparam int PROD_W = COEFF_W + SAMPLE_WIDTH;
    localparam logic [ACC_W-1:0] HALF = ACC_W'(1) << (FRAC_BITS - 1);

    logic signed [SAMPLE_WIDTH-1:0] prev_in_1_reg;
    logic signed [SAMPLE_WIDTH-1:0] prev_in_2_reg;
    logic signed [SAMPLE_WIDTH-1:0] prev_out_1_reg;
    logic signed [SAMPLE_WIDTH-1:0] prev_out_2_reg;

    logic signed [PROD_W-1:0]       prod_0;
    logic signed [PROD_W-1:0]       prod_1;
    logic signed [PROD_W-1:0]       prod_2;
    logic signed [PROD_W-1:0]       prod_3;
    logic signed [PROD_W-1:0]       prod_4;
    logic signed [ACC_W-1:0]        acc;
    logic signed [ACC_W-1:0]        rounded;
    logic signed [ACC_W-1:0]        shifted;
    logic signed [SAMPLE_WIDTH-1:0] y_next;
    logic [ACC_W-SAMPLE_WIDTH:0]    upper;

    // Five independent products, exact at full width
    always_comb
    begin
        prod_0 = coeffs.ff_coeff_0 * x_in;
        prod_1 = coeffs.ff_coeff_1 * prev_in_1_reg;
        prod_2 = coeffs.ff_coeff_2 * prev_in_2_reg;
        prod_3 = coeffs.fb_coeff_1 * prev_out_1_reg;
        prod_4 = coeffs.fb_coeff_2 * prev_out_2_reg;
    end

    // Accumulate modulo 2^64, add half (subtract it when negative), shift down
    always_comb
    begin
        acc = ACC_W'(prod_0) + ACC_W'(prod_1) + ACC_W'(prod_2)
            - ACC_W'(prod_3) - ACC_W'(prod_4);
        if (acc[ACC_W-1])
            rounded = acc - HALF;
        else
            rounded = acc + HALF;
        shifted = rounded >>> FRAC_BITS;
        y_next  = shifted[SAMPLE_WIDTH-1:0];
        upper   = shifted[ACC_W-1:SAMPLE_WIDTH-1];
    end

    // Flag when the bits above the sample are not a pure sign extension
    assign ovf_out = (|upper) && !(&upper);
    assign y_out   = PORT_W'(y_next);

    // Shift the histories as each sample moves to the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_in_1_reg  <= '0;
            prev_in_2_reg  <= '0;
            prev_out_1_reg <= '0;
            prev_out_2_reg <= '0;
        end
        else if (advance)
        begin
            prev_in_2_reg  <= prev_in_1_reg;
            prev_in_1_reg  <= x_in;
            prev_out_2_reg <= prev_out_1_reg;
            prev_out_1_reg <= y_next;
        end
    end

endmodule

// ===== dv/biquad_filter_q16_tb.sv =====
module biquad_filter_q16_tb
    import bqf_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC_BITS     = 16;
    localparam int SAMPLE_WIDTH  = 32;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 240;
    localparam int HOLD_CYCLES   = 400;
    localparam int QUIET_LIMIT   = 2000;
    localparam int DRAIN_CYCLES  = 8;

    localparam logic signed [ACC_W-1:0]  ROUND_HALF = 64'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [PORT_W-1:0] SMP_MIN    = 32'sh8000_0000;
    localparam logic signed [PORT_W-1:0] SMP_MAX    = 32'sh7FFF_FFFF;
    localparam logic signed [PORT_W-1:0] UNITY      = 32'sh0001_0000;

    typedef struct {
        logic signed [PORT_W-1:0] sample_out;
        logic                     overflow;
    } filt_result_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cfg_we = 1'b0;
    logic [REG_IDX_W-1:0]     cfg_index = '0;
    logic [COEFF_W-1:0]       cfg_data = '0;
    logic                     sample_valid = 1'b0;
    logic                     sample_stall;
    logic signed [PORT_W-1:0] sample_in = '0;
    logic                     result_valid;
    logic                     result_stall = 1'b0;
    logic signed [PORT_W-1:0] sample_out;
    logic                     overflow;

    wire in_fire  = sample_valid && !sample_stall;
    wire out_fire = result_valid && !result_stall;

    // Filter state mirrored by the predictor
    coeff_set_t               coeffs;
    logic signed [PORT_W-1:0] prev_in_1;
    logic signed [PORT_W-1:0] prev_in_2;
    logic signed [PORT_W-1:0] prev_out_1;
    logic signed [PORT_W-1:0] prev_out_2;

    logic signed [PORT_W-1:0] pending_samples [$];
    filt_result_t             expected_results [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int send_gap = 0;
    int stall_left = 0;
    int hold_left = 0;
    int hold_requests = 0;
    int hold_served = 0;
    int quiet_cycles = 0;
    int fail_count = 0;

    biquad_filter_q16 #(
        .FRAC_BITS    (FRAC_BITS),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample_in    (sample_in),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .sample_out   (sample_out),
        .overflow     (overflow)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Exact signed 32x32 product in the 64-bit accumulator width
    function automatic logic signed [ACC_W-1:0] wide_mul(input logic signed [PORT_W-1:0] a,
                                                       input logic signed [PORT_W-1:0] b);
        logic signed [ACC_W-1:0] wa;
        logic signed [ACC_W-1:0] wb;
        wa = $signed({{(ACC_W-PORT_W){a[PORT_W-1]}}, a});
        wb = $signed({{(ACC_W-PORT_W){b[PORT_W-1]}}, b});
        return wa * wb;
    endfunction

    // Run one sample through the mirrored filter and advance its history
    function automatic filt_result_t filter_step(input logic signed [PORT_W-1:0] x);
        logic signed [ACC_W-1:0] acc;
        logic signed [ACC_W-1:0] shifted;
        filt_result_t            res;
        acc = wide_mul(coeffs.ff_coeff_0, x) + wide_mul(coeffs.ff_coeff_1, prev_in_1)
            + wide_mul(coeffs.ff_coeff_2, prev_in_2) - wide_mul(coeffs.fb_coeff_1, prev_out_1)
            - wide_mul(coeffs.fb_coeff_2, prev_out_2);
        // add half to a non-negative wrapped sum, subtract it from a negative one
        if (!acc[ACC_W-1])
            acc = acc + ROUND_HALF;
        else
            acc = acc - ROUND_HALF;
        shifted = acc >>> FRAC_BITS;
        res.sample_out = shifted[PORT_W-1:0];
        res.overflow = (shifted != {{(ACC_W-PORT_W){shifted[PORT_W-1]}}, shifted[PORT_W-1:0]});
        prev_in_2 = prev_in_1;
        prev_in_1 = x;
        prev_out_2 = prev_out_1;
        prev_out_1 = res.sample_out;
        return res;
    endfunction

    function automatic logic signed [PORT_W-1:0] rand_sample();
        int pick;
        pick = $urandom_range(9);
        if (pick < 5)
            return $urandom;
        else if (pick < 8)
            return $signed(int'($urandom_range(2097152)) - 1048576);
        case ($urandom_range(5))
            0: return SMP_MIN;
            1: return SMP_MAX;
            2: return '0;
            3: return 32'sd1;
            4: return -32'sd1;
            default: return 32'sh0000_8000;
        endcase
    endfunction

    function automatic logic signed [PORT_W-1:0] rand_coeff(input int style);
        if (style == 0)
            return $urandom;
        if (style == 1)
            return $signed(int'($urandom_range(262144)) - 131072);
        case ($urandom_range(4))
            0: return SMP_MIN;
            1: return SMP_MAX;
            2: return '0;
            3: return UNITY;
            default: return -UNITY;
        endcase
    endfunction

    function automatic coeff_set_t rand_coeffs(input int style);
        coeff_set_t set;
        if (style == 3)
        begin
            // stable low-pass section
            set.ff_coeff_0 = 32'sd4424;
            set.ff_coeff_1 = 32'sd8848;
            set.ff_coeff_2 = 32'sd4424;
            set.fb_coeff_1 = -32'sd74907;
            set.fb_coeff_2 = 32'sd27053;
            return set;
        end
        set.ff_coeff_0 = rand_coeff(style);
        set.ff_coeff_1 = rand_coeff(style);
        set.ff_coeff_2 = rand_coeff(style);
        set.fb_coeff_1 = rand_coeff(style);
        set.fb_coeff_2 = rand_coeff(style);
        return set;
    endfunction

    function automatic int rand_idle_pct();
        case ($urandom_range(3))
            0: return 0;
            1: return 15;
            2: return 40;
            default: return 70;
        endcase
    endfunction

    // Issue one register write; the enable stays up until write_coeff_set drops it
    task automatic write_coeff(input logic [REG_IDX_W-1:0] idx,
                               input logic signed [COEFF_W-1:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        case (idx)
            REG_FF_COEFF_0: coeffs.ff_coeff_0 = value;
            REG_FF_COEFF_1: coeffs.ff_coeff_1 = value;
            REG_FF_COEFF_2: coeffs.ff_coeff_2 = value;
            REG_FB_COEFF_1: coeffs.fb_coeff_1 = value;
            REG_FB_COEFF_2: coeffs.fb_coeff_2 = value;
            default: ;
        endcase
    endtask

    task automatic write_coeff_set(input coeff_set_t set, input bit poke_spare);
        if (poke_spare)
            write_coeff(REG_IDX_W'($urandom_range(2**REG_IDX_W - 1, NUM_REGS)), $urandom);
        write_coeff(REG_FF_COEFF_0, set.ff_coeff_0);
        write_coeff(REG_FF_COEFF_1, set.ff_coeff_1);
        write_coeff(REG_FF_COEFF_2, set.ff_coeff_2);
        write_coeff(REG_FB_COEFF_1, set.fb_coeff_1);
        write_coeff(REG_FB_COEFF_2, set.fb_coeff_2);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Hold until every request has gone in and every result has come out
    task automatic wait_idle();
        while (pending_samples.size() != 0 || sample_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    function automatic coeff_set_t uniform_set(input logic signed [COEFF_W-1:0] value);
        coeff_set_t set;
        set.ff_coeff_0 = value;
        set.ff_coeff_1 = value;
        set.ff_coeff_2 = value;
        set.fb_coeff_1 = value;
        set.fb_coeff_2 = value;
        return set;
    endfunction

    // Sender: offer queued requests, hold while stalled, idle in bursts
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_valid <= 1'b0;
            sample_in <= '0;
            send_gap <= 0;
        end
        else if (!(sample_valid && sample_stall))
        begin
            if (sample_valid)
                expected_results.push_back(filter_step(sample_in));
            if (send_gap != 0)
            begin
                send_gap <= send_gap - 1;
                sample_valid <= 1'b0;
            end
            else if (pending_samples.size() != 0 && $urandom_range(99) < send_idle_pct)
            begin
                send_gap <= $urandom_range(16);
                sample_valid <= 1'b0;
            end
            else if (pending_samples.size() != 0)
            begin
                sample_valid <= 1'b1;
                sample_in <= pending_samples.pop_front();
            end
            else
                sample_valid <= 1'b0;
        end
    end

    // Receiver: check each result, stall in bursts or for a long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        filt_result_t want;
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            stall_left <= 0;
            hold_left <= 0;
            hold_served <= 0;
        end
        else
        begin
            if (out_fire)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result with nothing expected: sample_out=%0d overflow=%0b",
                           sample_out, overflow);
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (sample_out !== want.sample_out)
                    begin
                        $error("sample_out: expected %0d, actual %0d",
                               want.sample_out, sample_out);
                        fail_count++;
                    end
                    if (overflow !== want.overflow)
                    begin
                        $error("overflow: expected %0b, actual %0b", want.overflow, overflow);
                        fail_count++;
                    end
                end
            end
            if (hold_served != hold_requests)
            begin
                hold_served <= hold_served + 1;
                hold_left <= HOLD_CYCLES;
                result_stall <= 1'b1;
            end
            else if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                result_stall <= 1'b1;
            end
            else if (stall_left != 0)
            begin
                stall_left <= stall_left - 1;
                result_stall <= 1'b1;
            end
            else if ($urandom_range(99) < recv_idle_pct)
            begin
                stall_left <= $urandom_range(16);
                result_stall <= 1'b1;
            end
            else
                result_stall <= 1'b0;
        end
    end

    // Abort when nothing moves on either channel for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_fire || out_fire)
                quiet_cycles <= 0;
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        coeff_set_t set;
        coeffs = '0;
        coeffs.ff_coeff_0 = UNITY;
        prev_in_1 = '0;
        prev_in_2 = '0;
        prev_out_1 = '0;
        prev_out_2 = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Pass-through coefficients out of reset: field extremes and rounding edges
        pending_samples.push_back(SMP_MIN);
        pending_samples.push_back(SMP_MAX);
        pending_samples.push_back('0);
        pending_samples.push_back(32'sd1);
        pending_samples.push_back(-32'sd1);
        pending_samples.push_back(32'sh0000_8000);
        pending_samples.push_back(-32'sh0000_8000);
        pending_samples.push_back(32'sh7FFF_8000);
        wait_idle();

        // Most negative coefficients: the accumulator wraps
        write_coeff_set(uniform_set(SMP_MIN), 1'b1);
        @(negedge clk);
        pending_samples.push_back(SMP_MAX);
        pending_samples.push_back(SMP_MIN);
        pending_samples.push_back(SMP_MAX);
        pending_samples.push_back(SMP_MIN);
        pending_samples.push_back(-32'sd1);
        wait_idle();

        write_coeff_set(uniform_set(SMP_MAX), 1'b0);
        @(negedge clk);
        pending_samples.push_back(SMP_MAX);
        pending_samples.push_back(SMP_MAX);
        pending_samples.push_back(SMP_MIN);
        pending_samples.push_back(32'sd1);
        wait_idle();

        // Large gain with no feedback: results leave the 32-bit range
        set = uniform_set('0);
        set.ff_coeff_0 = SMP_MAX;
        write_coeff_set(set, 1'b1);
        @(negedge clk);
        pending_samples.push_back(SMP_MAX);
        pending_samples.push_back(SMP_MIN);
        pending_samples.push_back(UNITY);
        pending_samples.push_back(UNITY + 32'sd1);
        wait_idle();

        // Random phases with varied coefficients and handshake pressure
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            write_coeff_set(rand_coeffs(phase % 4), 1'($urandom_range(1)));
            if (phase == RANDOM_PHASES - 1)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            else
            begin
                send_idle_pct = rand_idle_pct();
                recv_idle_pct = rand_idle_pct();
            end
            @(negedge clk);
            if (phase == 1 || phase == 5)
                hold_requests++;
            for (int i = 0; i < PHASE_ITEMS; i++)
                pending_samples.push_back(rand_sample());
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_results.size() != 0)
        begin
            $error("%0d results never arrived", expected_results.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
